>>> hdl/interrupt_source_state_table_assert.svh
// Assertion macros for the interrupt source state table
`ifndef INTERRUPT_SOURCE_STATE_TABLE_ASSERT_SVH
`define INTERRUPT_SOURCE_STATE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISST_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISST_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/isst_pkg.sv
// Types, constants and codes shared by the interrupt source state table
`default_nettype none
package isst_pkg;

	localparam int NUM_SOURCES = 64;
	localparam int NUM_CLASSES = 4;
	localparam int NUM_THREADS = 16;

	localparam int OP_W   = 3;
	localparam int CLS_W  = 2;
	localparam int SRC_W  = 6;
	localparam int THR_W  = 4;
	localparam int PAY_W  = 32;
	localparam int STS_W  = 3;
	localparam int FLG_W  = 5;
	localparam int KIND_W = 2;
	localparam int MASK_W = 4;

	localparam int ADDR_W      = CLS_W + SRC_W;
	localparam int TABLE_DEPTH = 1 << ADDR_W;

	// flag bit positions
	localparam int FB_INUSE    = 0;
	localparam int FB_DISABLED = 1;
	localparam int FB_PENDING  = 2;
	localparam int FB_OUTSTAND = 3;
	localparam int FB_THREAD   = 4;

	localparam logic [FLG_W-1:0] F_CLAIMED = FLG_W'(1) << FB_INUSE;
	localparam logic [FLG_W-1:0] F_BOUND   = (FLG_W'(1) << FB_INUSE)
		| (FLG_W'(1) << FB_DISABLED) | (FLG_W'(1) << FB_THREAD);

	typedef enum logic [OP_W-1:0] {
		OP_INJECT    = 3'd0,
		OP_EOI       = 3'd1,
		OP_ENABLE    = 3'd2,
		OP_DISABLE   = 3'd3,
		OP_BIND      = 3'd4,
		OP_UNBIND    = 3'd5,
		OP_FIND_FREE = 3'd6,
		OP_GRAB      = 3'd7
	} opcode_t;

	typedef enum logic [STS_W-1:0] {
		ST_OK        = 3'd0,
		ST_DROPPED   = 3'd1,
		ST_LATCHED   = 3'd2,
		ST_COALESCED = 3'd3,
		ST_UNAVAIL   = 3'd4,
		ST_NONE_FREE = 3'd5,
		ST_CLASS     = 3'd6
	} status_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_DEFAULT = 2'd0,
		KIND_THREAD  = 2'd1,
		KIND_NONE    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [CLS_W-1:0] class_id;
		logic [SRC_W-1:0] source_id;
		logic [THR_W-1:0] target_thread_in;
		logic [PAY_W-1:0] payload;
	} in_item_t;

	typedef struct packed {
		logic [STS_W-1:0] status;
		logic             deliver;
		logic [THR_W-1:0] target_thread;
		logic [SRC_W-1:0] source_index;
		logic [CLS_W-1:0] class_out;
		logic [PAY_W-1:0] payload_out;
	} out_item_t;

	typedef struct packed {
		logic [THR_W-1:0]  thread;
		logic [KIND_W-1:0] kind;
		logic [FLG_W-1:0]  flags;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic load;    // latch transaction, read its entry
		logic step;    // advance find-free scan
		logic commit;  // write back entry, load result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_more;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> hdl/isst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module isst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/isst_ctrl.sv
// Controller state machine for the interrupt source state table
`default_nettype none
module isst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire isst_pkg::dp_sts_t sts,
	output isst_pkg::dp_cmd_t      cmd
);

	import isst_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_EXEC: begin
				if (sts.scan_more) begin
					cmd.step = 1'b1;
				end else begin
					cmd.commit = sts.out_free;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!sts.scan_more && sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/isst_dp.sv
// Datapath: source table, entry update logic, config register, result register
`default_nettype none
module isst_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire isst_pkg::in_item_t         in_data,
	input  wire logic                       cfg_valid,
	input  wire logic [isst_pkg::MASK_W-1:0] cfg_data,
	input  wire isst_pkg::dp_cmd_t          cmd,
	output isst_pkg::dp_sts_t               sts,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output isst_pkg::out_item_t             out_data
);

	import isst_pkg::*;

	in_item_t               item_q;
	logic [SRC_W-1:0]       scan_idx_q;
	logic [MASK_W-1:0]      class_handler_mask_q;
	logic [TABLE_DEPTH-1:0] vld_q;
	logic                   vld_s1;
	logic                   out_valid_q;
	out_item_t              out_data_q;

	logic [ADDR_W-1:0]  rd_addr;
	logic [ADDR_W-1:0]  wr_addr;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             ent;
	entry_t             nxt;
	out_item_t          res;
	logic               wr_need;
	logic               do_inject;
	logic [PAY_W-1:0]   inj_pay;
	logic               cls_ok;
	logic               src_ok;
	logic               thr_ok;
	logic               def_hdl;
	logic               eff_zero;
	logic               has_hdl;
	logic               is_ff;
	logic               scan_last;
	logic               wr_en;

	assign rd_en = cmd.load | cmd.step;
	// find-free starts at source 0 of the class; the scan then walks up
	assign rd_addr = cmd.load
		? {in_data.class_id,
		   (in_data.opcode == OP_FIND_FREE) ? SRC_W'(0) : in_data.source_id}
		: {item_q.class_id, SRC_W'(scan_idx_q + SRC_W'(1))};
	assign is_ff   = (item_q.opcode == OP_FIND_FREE);
	assign wr_addr = {item_q.class_id, is_ff ? scan_idx_q : item_q.source_id};
	assign wr_en   = cmd.commit & wr_need;

	isst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(nxt),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		// never-written entries read as reset (all zero)
		ent       = vld_s1 ? entry_t'(rd_data) : '0;
		cls_ok    = int'(item_q.class_id) < NUM_CLASSES;
		src_ok    = int'(item_q.source_id) < NUM_SOURCES;
		thr_ok    = int'(item_q.target_thread_in) < NUM_THREADS;
		def_hdl   = (ent.kind == KIND_DEFAULT) && class_handler_mask_q[item_q.class_id];
		eff_zero  = (ent.flags == '0) && !def_hdl;
		has_hdl   = (ent.kind == KIND_THREAD) || def_hdl;
		scan_last = (scan_idx_q == SRC_W'(NUM_SOURCES - 1));

		nxt       = ent;
		wr_need   = 1'b0;
		do_inject = 1'b0;
		inj_pay   = item_q.payload;
		res               = '0;
		res.status        = ST_OK;
		res.source_index  = item_q.source_id;
		res.class_out     = item_q.class_id;

		if (!cls_ok) begin
			res.status = ST_DROPPED;
		end else if (is_ff) begin
			res.source_index = scan_idx_q;
			if (eff_zero) begin
				nxt.flags = F_CLAIMED;
				wr_need   = 1'b1;
			end else begin
				res.status       = ST_NONE_FREE;
				res.source_index = '0;
			end
		end else if (!src_ok) begin
			res.status = ST_DROPPED;
		end else begin
			case (item_q.opcode)
				OP_INJECT: begin
					do_inject = 1'b1;
				end
				OP_EOI: begin
					nxt.flags[FB_OUTSTAND] = 1'b0;
					wr_need                = 1'b1;
					res.target_thread      = ent.thread;
				end
				OP_ENABLE: begin
					nxt.flags[FB_DISABLED] = 1'b0;
					wr_need                = 1'b1;
					// pending source re-injected with a zero payload
					if (ent.flags[FB_DISABLED] && ent.flags[FB_PENDING]) begin
						do_inject = 1'b1;
						inj_pay   = '0;
					end
				end
				OP_DISABLE: begin
					nxt.flags[FB_DISABLED] = 1'b1;
					wr_need                = 1'b1;
				end
				OP_BIND: begin
					if (!thr_ok) begin
						res.status = ST_DROPPED;
					end else if (has_hdl) begin
						res.status = ST_UNAVAIL;
					end else begin
						nxt.flags  = F_BOUND;
						nxt.kind   = KIND_THREAD;
						nxt.thread = item_q.target_thread_in;
						wr_need    = 1'b1;
					end
				end
				OP_UNBIND: begin
					nxt.flags  = '0;
					nxt.kind   = KIND_NONE;
					nxt.thread = '0;
					wr_need    = 1'b1;
				end
				OP_GRAB: begin
					if (eff_zero) begin
						nxt.flags = F_CLAIMED;
						wr_need   = 1'b1;
					end else begin
						res.status = ST_UNAVAIL;
					end
				end
				default: begin
					res.status = ST_OK;
				end
			endcase
		end

		// inject works on the flags as updated above (enable clears disabled first)
		if (do_inject) begin
			if (nxt.flags[FB_DISABLED]) begin
				nxt.flags[FB_PENDING] = 1'b1;
				wr_need               = 1'b1;
				res.status            = ST_LATCHED;
			end else if (ent.kind == KIND_THREAD) begin
				if (nxt.flags[FB_OUTSTAND]) begin
					res.status = ST_COALESCED;
				end else begin
					nxt.flags[FB_OUTSTAND] = 1'b1;
					nxt.flags[FB_PENDING]  = 1'b0;
					wr_need                = 1'b1;
					res.deliver            = 1'b1;
					res.target_thread      = ent.thread;
				end
			end else if (def_hdl) begin
				res.status      = ST_CLASS;
				res.payload_out = inj_pay;
			end else begin
				res.status = ST_DROPPED;
			end
		end

		sts.scan_more = cls_ok && is_ff && !eff_zero && !scan_last;
		sts.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.commit) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q           <= '0;
			class_handler_mask_q <= '0;
			vld_q                <= '0;
			vld_s1               <= 1'b0;
			out_valid_q          <= 1'b0;
		end else begin
			if (cfg_valid) begin
				class_handler_mask_q <= cfg_data;
			end
			if (cmd.load) begin
				scan_idx_q <= '0;
			end else if (cmd.step) begin
				scan_idx_q <= scan_idx_q + SRC_W'(1);
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

>>> hdl/interrupt_source_state_table.sv
// Top level of the interrupt source state table
`default_nettype none
// Interrupt source state table: one table of 64 sources for each of 4 classes,
// each entry holding in-use/disabled/pending/outstanding/thread-bound flags, a
// handler kind and a bound thread, held in a 256 x 11 RAM. Every transaction
// yields exactly one result. A normal operation is accepted (table read
// issued) and then executes, writing the entry back and loading the result
// register. Find-free scans its class one entry per cycle through the RAM
// read port and stops at the first free entry it finds, or at the last
// entry of the class when none is free. The result register
// lets the next transaction be accepted while a result still waits; execute
// stalls only when that register is still full. Per-entry valid bits make the
// table read as all zero after reset, so no clearing pass is needed. The
// class handler mask register is writable at any time (cfg_ready is always
// high) but should only be changed while the block is idle.
module interrupt_source_state_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire isst_pkg::in_item_t          in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output isst_pkg::out_item_t              out_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [isst_pkg::MASK_W-1:0] cfg_data
);

	import isst_pkg::*;

	`include "interrupt_source_state_table_assert.svh"

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	isst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	isst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	`ISST_ASSERT_IMP(a_deliver_ok, out_valid && out_data.deliver, out_data.status == ST_OK, "delivery with non-ok status")
	`ISST_ASSERT_IMP(a_payload_class, out_valid && (out_data.status != ST_CLASS), out_data.payload_out == '0, "payload out without class handler")
	`ISST_ASSERT_IMP(a_none_free_idx, out_valid && (out_data.status == ST_NONE_FREE), out_data.source_index == '0, "none free with nonzero index")
	`ISST_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule
`default_nettype wire
